### src/pjsd_pkg.sv
// ----------------------------------------------------------------------------
// pjsd_pkg
// Types, opcode constants and the stub matching function shared by the
// prologue jump stub detector.
// ----------------------------------------------------------------------------
package pjsd_pkg;

	localparam int ProLen   = 17;
	localparam int CountW   = 6;
	localparam int AddrW    = 64;
	localparam int CfgDataW = 64;
	localparam int CfgIdxW  = 1;

	typedef enum logic [2:0] {
		KIND_NONE       = 3'd0,
		KIND_JMP_REL    = 3'd1,
		KIND_JMP_RIP    = 3'd2,
		KIND_MOVABS_RAX = 3'd3,
		KIND_MOVABS_R11 = 3'd4,
		KIND_PUSH_RET   = 3'd5
	} stub_kind_t;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_TEXT_LOW  = 1'b0,
		CFG_TEXT_HIGH = 1'b1
	} cfg_reg_t;

	// Opcode bytes.
	localparam logic [7:0] OP_ENDBR_0  = 8'hf3;
	localparam logic [7:0] OP_ENDBR_1  = 8'h0f;
	localparam logic [7:0] OP_ENDBR_2  = 8'h1e;
	localparam logic [7:0] OP_ENDBR_3  = 8'hfa;
	localparam logic [7:0] OP_JMP_REL  = 8'he9;
	localparam logic [7:0] OP_GRP5     = 8'hff;
	localparam logic [7:0] OP_MODRM_RIP = 8'h25;
	localparam logic [7:0] OP_REX_W    = 8'h48;
	localparam logic [7:0] OP_REX_WB   = 8'h49;
	localparam logic [7:0] OP_REX_B    = 8'h41;
	localparam logic [7:0] OP_MOV_RAX  = 8'hb8;
	localparam logic [7:0] OP_MOV_R11  = 8'hbb;
	localparam logic [7:0] OP_MODRM_RAX = 8'he0;
	localparam logic [7:0] OP_MODRM_R11 = 8'he3;
	localparam logic [7:0] OP_PUSH_IMM = 8'h68;
	localparam logic [7:0] OP_RET      = 8'hc3;

	typedef logic [ProLen-1:0][7:0] pro_bytes_t;

	typedef struct packed {
		stub_kind_t  kind;
		logic [31:0] imm32;
		logic [63:0] imm64;
	} match_t;

	// Stage 1 to stage 2.
	typedef struct packed {
		stub_kind_t       kind;
		logic [AddrW-1:0] rel_add;
		logic [AddrW-1:0] abs_target;
		logic [AddrW-1:0] addr;
	} s1_t;

	// Stage 2 to stage 3.
	typedef struct packed {
		stub_kind_t       kind;
		logic [AddrW-1:0] target;
	} s2_t;

	// Result of stage 3.
	typedef struct packed {
		stub_kind_t       kind;
		logic [AddrW-1:0] target;
		logic             outside;
		logic             hook;
	} res_t;

	// Tries the five stubs at byte offset o; the first match wins.
	function automatic match_t try_at(pro_bytes_t b, logic [CountW-1:0] cnt, logic [4:0] o);
		match_t           m;
		logic [CountW-1:0] base;
		base    = {1'b0, o};
		m.imm32 = {b[o + 5'd4], b[o + 5'd3], b[o + 5'd2], b[o + 5'd1]};
		m.imm64 = {b[o + 5'd9], b[o + 5'd8], b[o + 5'd7], b[o + 5'd6],
		           b[o + 5'd5], b[o + 5'd4], b[o + 5'd3], b[o + 5'd2]};
		priority if (cnt >= base + 6'd5 && b[o] == OP_JMP_REL) begin
			m.kind = KIND_JMP_REL;
		end else if (cnt >= base + 6'd6 && b[o] == OP_GRP5 && b[o + 5'd1] == OP_MODRM_RIP) begin
			m.kind = KIND_JMP_RIP;
		end else if (cnt >= base + 6'd12 && b[o] == OP_REX_W && b[o + 5'd1] == OP_MOV_RAX &&
		             b[o + 5'd10] == OP_GRP5 && b[o + 5'd11] == OP_MODRM_RAX) begin
			m.kind = KIND_MOVABS_RAX;
		end else if (cnt >= base + 6'd13 && b[o] == OP_REX_WB && b[o + 5'd1] == OP_MOV_R11 &&
		             b[o + 5'd10] == OP_REX_B && b[o + 5'd11] == OP_GRP5 &&
		             b[o + 5'd12] == OP_MODRM_R11) begin
			m.kind = KIND_MOVABS_R11;
		end else if (cnt >= base + 6'd6 && b[o] == OP_PUSH_IMM && b[o + 5'd5] == OP_RET) begin
			m.kind = KIND_PUSH_RET;
		end else begin
			m.kind = KIND_NONE;
		end
		return m;
	endfunction

endpackage

### src/pjsd_prologue_if.sv
// ----------------------------------------------------------------------------
// pjsd_prologue_if
// Input channel: one function prologue per item.
// ----------------------------------------------------------------------------
interface pjsd_prologue_if;
	import pjsd_pkg::*;

	logic              valid;
	logic              ready;
	logic [63:0]       bytes_low;
	logic [63:0]       bytes_mid;
	logic [7:0]        byte_last;
	logic [CountW-1:0] byte_count;
	logic [AddrW-1:0]  func_address;

	modport source (
		output valid, bytes_low, bytes_mid, byte_last, byte_count, func_address,
		input  ready
	);

	modport sink (
		input  valid, bytes_low, bytes_mid, byte_last, byte_count, func_address,
		output ready
	);
endinterface

### src/pjsd_result_if.sv
// ----------------------------------------------------------------------------
// pjsd_result_if
// Output channel: one detection result per item.
// ----------------------------------------------------------------------------
interface pjsd_result_if;
	import pjsd_pkg::*;

	logic             valid;
	logic             ready;
	stub_kind_t       stub_kind;
	logic [AddrW-1:0] jump_target;
	logic             outside_text;
	logic             hook_found;

	modport source (
		output valid, stub_kind, jump_target, outside_text, hook_found,
		input  ready
	);

	modport sink (
		input  valid, stub_kind, jump_target, outside_text, hook_found,
		output ready
	);
endinterface

### src/pjsd_match.sv
// ----------------------------------------------------------------------------
// pjsd_match
// Stage 1: stub pattern match at offsets 0 and 4, immediate extraction.
// ----------------------------------------------------------------------------
module pjsd_match (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  pjsd_pkg::pro_bytes_t       in_bytes,
	input  logic [pjsd_pkg::CountW-1:0] in_count,
	input  logic [pjsd_pkg::AddrW-1:0] in_addr,
	output logic                       out_valid,
	input  logic                       out_ready,
	output pjsd_pkg::s1_t              out_data
);
	import pjsd_pkg::*;

	match_t     m0, m4, msel;
	logic       endbr, use_m0;
	logic [AddrW-1:0] next_len;
	s1_t        d_next, d_s1;
	logic       v_s1;

	always_comb begin
		m0    = try_at(in_bytes, in_count, 5'd0);
		m4    = try_at(in_bytes, in_count, 5'd4);
		endbr = in_count >= 6'd4 && in_bytes[0] == OP_ENDBR_0 && in_bytes[1] == OP_ENDBR_1 &&
		        in_bytes[2] == OP_ENDBR_2 && in_bytes[3] == OP_ENDBR_3;
		use_m0 = m0.kind != KIND_NONE || !endbr;
		msel   = use_m0 ? m0 : m4;
		// Offset of the stub plus the five bytes of jmp rel32.
		next_len = use_m0 ? 64'd5 : 64'd9;
		d_next.kind    = msel.kind;
		d_next.rel_add = {{32{msel.imm32[31]}}, msel.imm32} + next_len;
		d_next.abs_target = (msel.kind == KIND_PUSH_RET) ?
		                    {{32{msel.imm32[31]}}, msel.imm32} : msel.imm64;
		d_next.addr    = in_addr;
	end

	assign in_ready = !v_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			d_s1 <= d_next;
		end
	end

	assign out_valid = v_s1;
	assign out_data  = d_s1;
endmodule

### src/pjsd_target.sv
// ----------------------------------------------------------------------------
// pjsd_target
// Stage 2: final jump target, including the relative address add.
// ----------------------------------------------------------------------------
module pjsd_target (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  pjsd_pkg::s1_t in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output pjsd_pkg::s2_t out_data
);
	import pjsd_pkg::*;

	s2_t  d_next, d_s2;
	logic v_s2;

	always_comb begin
		d_next.kind = in_data.kind;
		unique case (in_data.kind)
			KIND_JMP_REL:    d_next.target = in_data.addr + in_data.rel_add;
			KIND_MOVABS_RAX,
			KIND_MOVABS_R11,
			KIND_PUSH_RET:   d_next.target = in_data.abs_target;
			default:         d_next.target = '0;
		endcase
	end

	assign in_ready = !v_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (in_ready) begin
			v_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			d_s2 <= d_next;
		end
	end

	assign out_valid = v_s2;
	assign out_data  = d_s2;
endmodule

### src/pjsd_check.sv
// ----------------------------------------------------------------------------
// pjsd_check
// Stage 3: text range check and hook flag; holds the result register.
// ----------------------------------------------------------------------------
module pjsd_check (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [pjsd_pkg::AddrW-1:0] text_low,
	input  logic [pjsd_pkg::AddrW-1:0] text_high,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  pjsd_pkg::s2_t              in_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output pjsd_pkg::res_t             out_data
);
	import pjsd_pkg::*;

	res_t d_next, d_s3;
	logic v_s3, direct;

	always_comb begin
		direct = in_data.kind != KIND_NONE && in_data.kind != KIND_JMP_RIP;
		d_next.kind    = in_data.kind;
		d_next.target  = in_data.target;
		d_next.outside = direct && (in_data.target < text_low || in_data.target >= text_high);
		d_next.hook    = d_next.outside || in_data.kind == KIND_JMP_RIP;
	end

	assign in_ready = !v_s3 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (in_ready) begin
			v_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			d_s3 <= d_next;
		end
	end

	assign out_valid = v_s3;
	assign out_data  = d_s3;
endmodule

### src/prologue_jump_stub_detector.sv
// ----------------------------------------------------------------------------
// prologue_jump_stub_detector
// Path: an accepted item passes the stage 1, stage 2 and stage 3 registers.
// Throughput: one item per cycle; the three pipeline registers each stall
// only when the stage after them is full and not being drained.
// Reset: arst_n clears all stage valid bits and both text range registers.
// ----------------------------------------------------------------------------
//
// Detects jump stubs at the head of an x86-64 function prologue. The block is
// a three-stage pipeline:
//   stage 1 (pjsd_match)  matches the five stub patterns at offset 0 and, when
//                         the prologue opens with endbr64, at offset 4. It
//                         extracts the immediates and prepares the relative
//                         displacement plus the instruction length.
//   stage 2 (pjsd_target) adds the function address for jmp rel32 and selects
//                         the final target, zero for no stub and for the
//                         indirect jump.
//   stage 3 (pjsd_check)  compares the target against the text range and sets
//                         the hook flag. Its register is the output register.
// Each stage has its own valid bit and is ready when empty or when the stage
// after it moves, so bubbles are squeezed out and a stalled output does not
// block earlier stages that still have room.
// Stage 3 reads the text range registers, written through the plain write
// port; change them only while no item is in flight, unenforced by the block.
// ----------------------------------------------------------------------------
module prologue_jump_stub_detector (
	input  logic                          clk,
	input  logic                          arst_n,
	pjsd_prologue_if.sink                 prologue,
	pjsd_result_if.source                 result,
	input  logic                          cfg_we,
	input  logic [pjsd_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [pjsd_pkg::CfgDataW-1:0] cfg_data
);
	import pjsd_pkg::*;

	logic [AddrW-1:0] text_low_q, text_high_q;
	pro_bytes_t       pro_bytes;

	logic v_s1, rdy_s2, v_s2, rdy_s3;
	s1_t  d_s1;
	s2_t  d_s2;
	res_t d_s3;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_low_q  <= '0;
			text_high_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_TEXT_LOW:  text_low_q  <= cfg_data;
				CFG_TEXT_HIGH: text_high_q <= cfg_data;
				default:       ;
			endcase
		end
	end

	// Byte 0 lands in the lowest byte lane.
	assign pro_bytes = {prologue.byte_last, prologue.bytes_mid, prologue.bytes_low};

	pjsd_match u_match (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (prologue.valid),
		.in_ready  (prologue.ready),
		.in_bytes  (pro_bytes),
		.in_count  (prologue.byte_count),
		.in_addr   (prologue.func_address),
		.out_valid (v_s1),
		.out_ready (rdy_s2),
		.out_data  (d_s1)
	);

	pjsd_target u_target (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s1),
		.in_ready  (rdy_s2),
		.in_data   (d_s1),
		.out_valid (v_s2),
		.out_ready (rdy_s3),
		.out_data  (d_s2)
	);

	pjsd_check u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.text_low  (text_low_q),
		.text_high (text_high_q),
		.in_valid  (v_s2),
		.in_ready  (rdy_s3),
		.in_data   (d_s2),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.out_data  (d_s3)
	);

	assign result.stub_kind    = d_s3.kind;
	assign result.jump_target  = d_s3.target;
	assign result.outside_text = d_s3.outside;
	assign result.hook_found   = d_s3.hook;

	// An accepted item always lands in stage 1.
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		prologue.valid && prologue.ready |=> v_s1)
		else $error("accepted item did not reach stage 1");

	// Stage 1 holds its item while stage 2 cannot take it.
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !rdy_s2 |=> v_s1 && $stable(d_s1))
		else $error("stage 1 item changed while stalled");

	// No stub and the indirect jump carry a zero target and no range flag.
	a_zero_target: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && (result.stub_kind == KIND_NONE || result.stub_kind == KIND_JMP_RIP)
		|-> result.jump_target == '0 && !result.outside_text)
		else $error("target or range flag set without a direct stub");

	// The hook flag comes from the range check or the indirect jump only.
	a_hook_cause: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |->
		result.hook_found == (result.outside_text || result.stub_kind == KIND_JMP_RIP))
		else $error("hook flag does not match its causes");
endmodule

### verif/prologue_jump_stub_detector_test.sv
// ----------------------------------------------------------------------------
// prologue_jump_stub_detector_test
// Self-checking bench for the x86-64 prologue jump stub detector.
// A short table of hand-built prologues goes first, under the empty text
// range that reset leaves. Then several text ranges are programmed, and each
// is followed by random prologues that mostly carry a real stub, with or
// without an endbr64 prefix. Each accepted prologue gets its expected result
// from the local model or a typed table row; results are compared in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module prologue_jump_stub_detector_test;
	import pjsd_pkg::*;

	localparam int ItemsPerRange = 275;
	localparam int RangeCount    = 6;
	localparam int CycleLimit    = 400000;
	localparam int HoldCycles    = 80;

	// One prologue as the input channel carries it.
	typedef struct {
		logic [63:0] lo;
		logic [63:0] mid;
		logic [7:0]  last;
		logic [5:0]  cnt;
		logic [63:0] addr;
	} prologue_t;

	// A row of the directed table. When typed is set, want holds the result
	// written out by hand; otherwise the local decoder supplies it.
	typedef struct {
		prologue_t pro;
		bit        typed;
		res_t      want;
	} probe_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic                cfg_we;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CfgDataW-1:0] cfg_data;

	pjsd_prologue_if pro_ch ();
	pjsd_result_if   res_ch ();

	prologue_jump_stub_detector dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.prologue  (pro_ch),
		.result    (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	// Local copy of the text range registers, updated as they are written.
	logic [63:0] win_low  = '0;
	logic [63:0] win_high = '0;

	// Decoded results still owed by the block, oldest first.
	res_t awaited_stubs [$];

	int  mismatch_cnt = 0;
	int  cycle_cnt    = 0;
	bit  no_idle      = 1'b0;  // both sides run flat out while set
	bit  hold_req     = 1'b0;  // asks the result side for a long stall

	// Hand-built prologues. Rows with a typed result run under the reset state,
	// where the text range is empty and so every direct target is outside.
	probe_row_t probe_table [21] = '{
		// Nothing valid at all.
		'{'{64'h0, 64'h0, 8'h00, 6'd0, 64'h0}, 1'b1, '{KIND_NONE, 64'h0, 1'b0, 1'b0}},
		// All ones everywhere, full count: ff ff is not a stub.
		'{'{64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 8'hff, 6'd32,
			64'hffff_ffff_ffff_ffff}, 1'b1, '{KIND_NONE, 64'h0, 1'b0, 1'b0}},
		// jmp rel32 with a zero displacement, exactly long enough, then one short.
		'{'{64'h0000_0000_0000_00e9, 64'h0, 8'h00, 6'd5, 64'h1000}, 1'b1,
			'{KIND_JMP_REL, 64'h1005, 1'b1, 1'b1}},
		'{'{64'h0000_0000_0000_00e9, 64'h0, 8'h00, 6'd4, 64'h1000}, 1'b1,
			'{KIND_NONE, 64'h0, 1'b0, 1'b0}},
		// jmp [rip+disp32]: indirect, so no target but a hook.
		'{'{64'h0000_0000_0000_25ff, 64'h0, 8'h00, 6'd6, 64'h4000}, 1'b1,
			'{KIND_JMP_RIP, 64'h0, 1'b0, 1'b1}},
		'{'{64'h0000_0000_0000_25ff, 64'h0, 8'h00, 6'd5, 64'h4000}, 1'b1,
			'{KIND_NONE, 64'h0, 1'b0, 1'b0}},
		// movabs rax, imm64; jmp rax.
		'{'{64'h3344_5566_7788_b848, 64'h0000_0000_e0ff_1122, 8'h00, 6'd12, 64'h0}, 1'b1,
			'{KIND_MOVABS_RAX, 64'h1122_3344_5566_7788, 1'b1, 1'b1}},
		'{'{64'h3344_5566_7788_b848, 64'h0000_0000_e0ff_1122, 8'h00, 6'd11, 64'h0}, 1'b1,
			'{KIND_NONE, 64'h0, 1'b0, 1'b0}},
		// movabs r11, imm64; jmp r11.
		'{'{64'h3344_5566_7788_bb49, 64'h0000_00e3_ff41_1122, 8'h00, 6'd13, 64'h0}, 1'b1,
			'{KIND_MOVABS_R11, 64'h1122_3344_5566_7788, 1'b1, 1'b1}},
		'{'{64'h3344_5566_7788_bb49, 64'h0000_00e3_ff41_1122, 8'h00, 6'd12, 64'h0}, 1'b1,
			'{KIND_NONE, 64'h0, 1'b0, 1'b0}},
		// push imm32; ret with the sign bit set, so the target is sign-extended.
		'{'{64'h0000_c380_0000_0068, 64'h0, 8'h00, 6'd6, 64'h0}, 1'b1,
			'{KIND_PUSH_RET, 64'hffff_ffff_8000_0000, 1'b1, 1'b1}},
		'{'{64'h0000_c380_0000_0068, 64'h0, 8'h00, 6'd5, 64'h0}, 1'b1,
			'{KIND_NONE, 64'h0, 1'b0, 1'b0}},
		// endbr64 then jmp rel32 backward by five.
		'{'{64'hffff_fbe9_fa1e_0ff3, 64'h0000_0000_0000_00ff, 8'h00, 6'd9, 64'h2000},
			1'b0, '{KIND_NONE, 64'h0, 1'b0, 1'b0}},
		// Largest forward displacement from the top of the address space wraps.
		'{'{64'h0000_007f_ffff_ffe9, 64'h0, 8'h00, 6'd5, 64'hffff_ffff_ffff_fff0},
			1'b0, '{KIND_NONE, 64'h0, 1'b0, 1'b0}},
		// endbr64 followed by each of the other stubs, each just long enough.
		'{'{64'h0000_25ff_fa1e_0ff3, 64'h0, 8'h00, 6'd10, 64'h0},
			1'b0, '{KIND_NONE, 64'h0, 1'b0, 1'b0}},
		'{'{64'hf00d_b848_fa1e_0ff3, 64'he0ff_dead_beef_cafe, 8'h00, 6'd16, 64'h0},
			1'b0, '{KIND_NONE, 64'h0, 1'b0, 1'b0}},
		'{'{64'hf00d_bb49_fa1e_0ff3, 64'hff41_dead_beef_cafe, 8'he3, 6'd17, 64'h0},
			1'b0, '{KIND_NONE, 64'h0, 1'b0, 1'b0}},
		'{'{64'h3456_7868_fa1e_0ff3, 64'h0000_0000_0000_c312, 8'h00, 6'd10, 64'h0},
			1'b0, '{KIND_NONE, 64'h0, 1'b0, 1'b0}},
		// endbr64 alone, and endbr64 with a jmp rel32 one byte short.
		'{'{64'h0000_0000_fa1e_0ff3, 64'h0, 8'h00, 6'd4, 64'h0},
			1'b0, '{KIND_NONE, 64'h0, 1'b0, 1'b0}},
		'{'{64'hffff_fbe9_fa1e_0ff3, 64'h0000_0000_0000_00ff, 8'h00, 6'd8, 64'h2000},
			1'b0, '{KIND_NONE, 64'h0, 1'b0, 1'b0}},
		// push of the largest positive imm32, with the full count.
		'{'{64'h0000_c37f_ffff_ff68, 64'h0, 8'h00, 6'd32, 64'h0},
			1'b0, '{KIND_NONE, 64'h0, 1'b0, 1'b0}}
	};

	// Text ranges run through after the table: a kernel-like window, the whole
	// space, an empty range at the top, the low 2 GiB, a random window, and a
	// reversed range.
	logic [63:0] range_low [RangeCount] = '{
		64'hffff_ffff_8000_0000, 64'h0, 64'hffff_ffff_ffff_ffff,
		64'h0, 64'h0, 64'hffff_ffff_c000_0000
	};
	logic [63:0] range_high [RangeCount] = '{
		64'hffff_ffff_c000_0000, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff,
		64'h0000_0000_8000_0000, 64'h0, 64'hffff_ffff_8000_0000
	};

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Tries the five stubs at byte offset o of the packed prologue, first match
	// wins. The immediates sit little-endian, so plain part-selects read them.
	function automatic stub_kind_t scan_offset(input logic [135:0] pro, input int cnt,
	                                           input int o, input logic [63:0] addr,
	                                           output logic [63:0] tgt);
		logic [7:0]  op;
		logic [7:0]  modrm;
		logic [31:0] imm32;
		logic [63:0] imm64;
		op    = pro[8*o +: 8];
		modrm = pro[8*(o+1) +: 8];
		imm32 = pro[8*(o+1) +: 32];
		imm64 = pro[8*(o+2) +: 64];
		tgt   = '0;
		if (cnt >= o + 5 && op == OP_JMP_REL) begin
			tgt = addr + 64'(o + 5) + {{32{imm32[31]}}, imm32};
			return KIND_JMP_REL;
		end
		if (cnt >= o + 6 && op == OP_GRP5 && modrm == OP_MODRM_RIP)
			return KIND_JMP_RIP;
		if (cnt >= o + 12 && op == OP_REX_W && modrm == OP_MOV_RAX &&
		    pro[8*(o+10) +: 8] == OP_GRP5 && pro[8*(o+11) +: 8] == OP_MODRM_RAX) begin
			tgt = imm64;
			return KIND_MOVABS_RAX;
		end
		if (cnt >= o + 13 && op == OP_REX_WB && modrm == OP_MOV_R11 &&
		    pro[8*(o+10) +: 8] == OP_REX_B && pro[8*(o+11) +: 8] == OP_GRP5 &&
		    pro[8*(o+12) +: 8] == OP_MODRM_R11) begin
			tgt = imm64;
			return KIND_MOVABS_R11;
		end
		if (cnt >= o + 6 && op == OP_PUSH_IMM && pro[8*(o+5) +: 8] == OP_RET) begin
			tgt = {{32{imm32[31]}}, imm32};
			return KIND_PUSH_RET;
		end
		return KIND_NONE;
	endfunction

	// Expected result for one prologue under the current text range.
	function automatic res_t decode_stub(prologue_t p);
		logic [135:0] pro;
		logic [63:0]  tgt;
		res_t         r;
		pro    = {p.last, p.mid, p.lo};
		r.kind = scan_offset(pro, int'(p.cnt), 0, p.addr, tgt);
		// An endbr64 prefix moves the stub four bytes in.
		if (r.kind == KIND_NONE && p.cnt >= 6'd4 &&
		    pro[31:0] == {OP_ENDBR_3, OP_ENDBR_2, OP_ENDBR_1, OP_ENDBR_0})
			r.kind = scan_offset(pro, int'(p.cnt), 4, p.addr, tgt);
		if (r.kind == KIND_NONE || r.kind == KIND_JMP_RIP)
			tgt = '0;
		r.target  = tgt;
		// An empty or reversed range puts every direct target outside.
		r.outside = (r.kind != KIND_NONE && r.kind != KIND_JMP_RIP) &&
		            (tgt < win_low || tgt >= win_high);
		r.hook    = r.outside || r.kind == KIND_JMP_RIP;
		return r;
	endfunction

	// A target that often lands on or next to the edges of the text range.
	function automatic logic [63:0] pick_target();
		case ($urandom_range(0, 7))
			0: return win_low;
			1: return win_low - 64'd1;
			2: return win_high;
			3: return win_high - 64'd1;
			4, 5: return (win_high > win_low) ? win_low + rand64() % (win_high - win_low)
			                                 : rand64();
			6: return {32'hffff_ffff, $urandom};
			default: return rand64();
		endcase
	endfunction

	// Random prologue: mostly a well-formed stub with random content, now and
	// then cut short or with one byte spoiled, and some pure noise.
	function automatic prologue_t random_prologue();
		logic [135:0] pro;
		logic [63:0]  tgt;
		logic [63:0]  addr;
		logic [31:0]  rel;
		logic [7:0]   lead [6];
		prologue_t    p;
		int           o;
		int           need;
		int           spot;
		lead          = '{OP_JMP_REL, OP_GRP5, OP_REX_W, OP_REX_WB, OP_PUSH_IMM, OP_ENDBR_0};
		pro[31:0]     = $urandom;
		pro[63:32]    = $urandom;
		pro[95:64]    = $urandom;
		pro[127:96]   = $urandom;
		pro[135:128]  = 8'($urandom);
		addr          = rand64();
		if ($urandom_range(0, 99) < 15) begin
			if ($urandom_range(0, 1) == 1)
				pro[7:0] = lead[$urandom_range(0, 5)];
			p.cnt = 6'($urandom_range(0, 32));
		end else begin
			o   = ($urandom_range(0, 1) == 1) ? 4 : 0;
			if (o == 4)
				pro[31:0] = {OP_ENDBR_3, OP_ENDBR_2, OP_ENDBR_1, OP_ENDBR_0};
			tgt = pick_target();
			case ($urandom_range(1, 5))
				1: begin
					rel = $urandom;
					pro[8*o +: 8]      = OP_JMP_REL;
					pro[8*(o+1) +: 32] = rel;
					// Back the function address off so the target comes out as picked.
					addr = tgt - 64'(o + 5) - {{32{rel[31]}}, rel};
					need = o + 5;
				end
				2: begin
					pro[8*o +: 16] = {OP_MODRM_RIP, OP_GRP5};
					need = o + 6;
				end
				3: begin
					pro[8*o +: 16]      = {OP_MOV_RAX, OP_REX_W};
					pro[8*(o+2) +: 64]  = tgt;
					pro[8*(o+10) +: 16] = {OP_MODRM_RAX, OP_GRP5};
					need = o + 12;
				end
				4: begin
					pro[8*o +: 16]      = {OP_MOV_R11, OP_REX_WB};
					pro[8*(o+2) +: 64]  = tgt;
					pro[8*(o+10) +: 24] = {OP_MODRM_R11, OP_GRP5, OP_REX_B};
					need = o + 13;
				end
				default: begin
					pro[8*o +: 8]      = OP_PUSH_IMM;
					pro[8*(o+1) +: 32] = ($urandom_range(0, 1) == 1) ? tgt[31:0] : $urandom;
					pro[8*(o+5) +: 8]  = OP_RET;
					need = o + 6;
				end
			endcase
			p.cnt = ($urandom_range(0, 99) < 80) ? 6'($urandom_range(need, 32))
			                                     : 6'($urandom_range(0, need - 1));
			if ($urandom_range(0, 99) < 10) begin
				spot = $urandom_range(0, 16);
				pro[8*spot +: 8] = pro[8*spot +: 8] ^ 8'($urandom_range(1, 255));
			end
		end
		p.lo   = pro[63:0];
		p.mid  = pro[127:64];
		p.last = pro[135:128];
		p.addr = addr;
		return p;
	endfunction

	task automatic flag_mismatch(input string what, input logic [63:0] got,
	                             input logic [63:0] want);
		$display("%0t: mismatch in %s: got %h, expected %h", $realtime, what, got, want);
		mismatch_cnt++;
	endtask

	// Offers one prologue after a random idle gap and, once it is taken, files
	// the result the block owes for it.
	task automatic offer_prologue(input prologue_t p, input bit typed, input res_t want);
		while (!no_idle && $urandom_range(0, 99) < 35) begin
			pro_ch.valid <= 1'b0;
			@(posedge clk);
		end
		pro_ch.valid        <= 1'b1;
		pro_ch.bytes_low    <= p.lo;
		pro_ch.bytes_mid    <= p.mid;
		pro_ch.byte_last    <= p.last;
		pro_ch.byte_count   <= p.cnt;
		pro_ch.func_address <= p.addr;
		do
			@(posedge clk);
		while (!pro_ch.ready);
		awaited_stubs.push_back(typed ? want : decode_stub(p));
	endtask

	// Lets the pipeline drain completely before the text range may change.
	task automatic drain_results();
		while (awaited_stubs.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_text_range(input logic [63:0] lo, input logic [63:0] hi);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_TEXT_LOW;
		cfg_data  <= lo;
		@(posedge clk);
		cfg_index <= CFG_TEXT_HIGH;
		cfg_data  <= hi;
		@(posedge clk);
		cfg_we   <= 1'b0;
		win_low  = lo;
		win_high = hi;
	endtask

	// Result side: checks every accepted result against the oldest expectation
	// and drives ready, with random stalls and the occasional long hold-off.
	initial begin
		res_t want;
		int   hold_left;
		hold_left    = 0;
		res_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && res_ch.valid && res_ch.ready) begin
				if (awaited_stubs.size() == 0) begin
					flag_mismatch("unexpected result kind", 64'(res_ch.stub_kind), 64'h0);
				end else begin
					want = awaited_stubs.pop_front();
					if (res_ch.stub_kind !== want.kind)
						flag_mismatch("stub_kind", 64'(res_ch.stub_kind), 64'(want.kind));
					if (res_ch.jump_target !== want.target)
						flag_mismatch("jump_target", res_ch.jump_target, want.target);
					if (res_ch.outside_text !== want.outside)
						flag_mismatch("outside_text", 64'(res_ch.outside_text),
						              64'(want.outside));
					if (res_ch.hook_found !== want.hook)
						flag_mismatch("hook_found", 64'(res_ch.hook_found), 64'(want.hook));
				end
			end
			// The long hold-off lets the three stages fill and push back on input.
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else if (hold_req) begin
				hold_req     = 1'b0;
				hold_left    = HoldCycles;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= no_idle || ($urandom_range(0, 99) >= 35);
			end
		end
	end

	// Watchdog on the whole run.
	initial begin
		while (cycle_cnt < CycleLimit) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	// Stimulus: reset, the directed table, then random prologues per text range.
	initial begin
		res_t      blank;
		prologue_t p;
		blank               = '{KIND_NONE, 64'h0, 1'b0, 1'b0};
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_index           = CFG_TEXT_LOW;
		cfg_data            = '0;
		pro_ch.valid        = 1'b0;
		pro_ch.bytes_low    = '0;
		pro_ch.bytes_mid    = '0;
		pro_ch.byte_last    = '0;
		pro_ch.byte_count   = '0;
		pro_ch.func_address = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset leaves both bounds at zero, so the table runs on an empty range.
		foreach (probe_table[i])
			offer_prologue(probe_table[i].pro, probe_table[i].typed, probe_table[i].want);
		pro_ch.valid <= 1'b0;

		for (int r = 0; r < RangeCount; r++) begin
			drain_results();
			if (r == 4)
				write_text_range(rand64() >> 1, rand64() | 64'h8000_0000_0000_0000);
			else
				write_text_range(range_low[r], range_high[r]);
			// The first range opens with a long stall on the result side; the
			// second opens with a stretch where neither side idles.
			if (r == 0)
				hold_req = 1'b1;
			if (r == 1)
				no_idle = 1'b1;
			for (int n = 0; n < ItemsPerRange; n++) begin
				if (n == 150)
					no_idle = 1'b0;
				p = random_prologue();
				offer_prologue(p, 1'b0, blank);
			end
			pro_ch.valid <= 1'b0;
		end

		drain_results();
		if (mismatch_cnt == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

### filelist.f
src/pjsd_pkg.sv
src/pjsd_prologue_if.sv
src/pjsd_result_if.sv
src/pjsd_match.sv
src/pjsd_target.sv
src/pjsd_check.sv
src/prologue_jump_stub_detector.sv
verif/prologue_jump_stub_detector_test.sv
